// ===== hw/rtl/kf2_pkg.sv =====
// ----------------------------------------------------------------------------
// Kalman filter package
// Shared constants and types for the two-state Kalman filter.
// ----------------------------------------------------------------------------
package kf2_pkg;

   localparam int DEFAULT_FRAC_BITS = 16;
   localparam int CSR_ADDR_W = 6;

   localparam logic [1:0] CMD_PREDICT = 2'd0;
   localparam logic [1:0] CMD_UPDATE  = 2'd1;
   localparam logic [1:0] CMD_BOTH    = 2'd2;
   localparam logic [1:0] CMD_RESTART = 2'd3;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_SKIP = 2'd1;
   localparam logic [1:0] STATUS_SAT  = 2'd2;

   localparam logic [2:0] REG_TRANS0 = 3'd0;
   localparam logic [2:0] REG_TRANS1 = 3'd1;
   localparam logic [2:0] REG_MEAS   = 3'd2;
   localparam logic [2:0] REG_QN0    = 3'd3;
   localparam logic [2:0] REG_QN1    = 3'd4;
   localparam logic [2:0] REG_RN     = 3'd5;
   localparam logic [2:0] REG_START  = 3'd6;

   typedef struct packed {
      logic [63:0] trans_row0;
      logic [63:0] trans_row1;
      logic [63:0] meas_row;
      logic [63:0] proc_noise_row0;
      logic [63:0] proc_noise_row1;
      logic [30:0] meas_noise;
      logic [63:0] start_state;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  command;
      logic signed [31:0] measurement;
   } req_type;

   typedef struct packed {
      logic signed [31:0] position_estimate;
      logic signed [31:0] velocity_estimate;
      logic [1:0]         status;
   } rsp_type;

endpackage

// ===== hw/rtl/kf2_if.sv =====
// ----------------------------------------------------------------------------
// Kalman filter channels
// Valid/ready channels for request and response beats.
// ----------------------------------------------------------------------------
interface kf2_req_if;
   import kf2_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface kf2_rsp_if;
   import kf2_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/kalman_filter_2state_scalar_meas_top.sv =====
// ----------------------------------------------------------------------------
// Two-state Kalman filter
// Predict/update/restart engine sharing one multiply-accumulate and a divider.
// ----------------------------------------------------------------------------
// Restart loads the start state and an identity P and goes straight to the response.
// Predict runs the x and P micro-ops on the shared multiply-accumulate; update forms
// ph and s, skips the rest when s is not positive, else divides for k and ends x and P.
// One request beat is in work at a time; the next is taken the cycle after its
// response is registered. The multiplier is shared by all micro-ops and the divider
// is bit-serial. Reset is synchronous: x=0, P=identity, registers at defaults.
module kalman_filter_2state_scalar_meas_top #(
   parameter int FRAC_BITS = kf2_pkg::DEFAULT_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   kf2_req_if.sink                       req,
   kf2_rsp_if.source                     rsp,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [kf2_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [63:0]                   csr_pwdata,
   output logic [63:0]                   csr_prdata,
   output logic                          csr_pready
);
   import kf2_pkg::*;

   localparam int DW = 32 + FRAC_BITS + 1;
   localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [65:0] HALF_Q = 66'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [65:0] WMAX = 66'sd2147483647;
   localparam logic signed [65:0] WMIN = -66'sd2147483648;

   typedef enum logic [2:0] {
      S_IDLE, S_MAC, S_DIV, S_OUT
   } state_type;

   cfg_type cfg;

   kf2_csr u_csr (
      .clock(clock), .reset(reset), .csr_psel(csr_psel), .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready), .cfg(cfg)
   );

   // Register file of words: 0,1 x; 2..5 P; 6..9 fp/a; 10,11 ph; 12 s;
   // 13,14 k; 15 hx; 16 innov; 17,18 next x; 19..22 next P.
   state_type          state_ff;
   logic signed [31:0] w_ff [23];
   logic [5:0]         op_ff;
   logic [1:0]         cmd_ff;
   logic signed [31:0] z_ff;
   logic               clamp_ff;
   logic               skip_ff;
   logic signed [65:0] acc_ff;
   logic [1:0]         term_ff;
   rsp_type            rsp_ff;
   logic               rvalid_ff;
   logic [DW-1:0]      rem_ff;
   logic [DW-1:0]      quo_ff;
   logic [DW-1:0]      dvs_ff;
   logic [6:0]         dcnt_ff;
   logic               dneg_ff;
   logic               kidx_ff;

   function automatic logic signed [31:0] wd(input logic [63:0] r, input logic hi);
      wd = hi ? r[63:32] : r[31:0];
   endfunction

   // Micro-op table: dest, two products (a*b + c*d) plus add term.
   logic signed [31:0] ma, mb, mc, md, madd;
   logic [4:0]         mdst;
   logic signed [31:0] f00, f01, f10, f11, h0, h1;

   assign f00 = wd(cfg.trans_row0, 1'b0);
   assign f01 = wd(cfg.trans_row0, 1'b1);
   assign f10 = wd(cfg.trans_row1, 1'b0);
   assign f11 = wd(cfg.trans_row1, 1'b1);
   assign h0 = wd(cfg.meas_row, 1'b0);
   assign h1 = wd(cfg.meas_row, 1'b1);

   always_comb begin
      ma = '0; mb = '0; mc = '0; md = '0; madd = '0; mdst = 5'd0;
      case (op_ff)
         6'd0: begin ma = f00; mb = w_ff[0]; mc = f01; md = w_ff[1]; mdst = 5'd17; end
         6'd1: begin ma = f10; mb = w_ff[0]; mc = f11; md = w_ff[1]; mdst = 5'd18; end
         6'd2: begin ma = f00; mb = w_ff[2]; mc = f01; md = w_ff[4]; mdst = 5'd6; end
         6'd3: begin ma = f00; mb = w_ff[3]; mc = f01; md = w_ff[5]; mdst = 5'd7; end
         6'd4: begin ma = f10; mb = w_ff[2]; mc = f11; md = w_ff[4]; mdst = 5'd8; end
         6'd5: begin ma = f10; mb = w_ff[3]; mc = f11; md = w_ff[5]; mdst = 5'd9; end
         6'd6: begin ma = w_ff[6]; mb = f00; mc = w_ff[7]; md = f01;
            madd = wd(cfg.proc_noise_row0, 1'b0); mdst = 5'd2; end
         6'd7: begin ma = w_ff[6]; mb = f10; mc = w_ff[7]; md = f11;
            madd = wd(cfg.proc_noise_row0, 1'b1); mdst = 5'd3; end
         6'd8: begin ma = w_ff[8]; mb = f00; mc = w_ff[9]; md = f01;
            madd = wd(cfg.proc_noise_row1, 1'b0); mdst = 5'd4; end
         6'd9: begin ma = w_ff[8]; mb = f10; mc = w_ff[9]; md = f11;
            madd = wd(cfg.proc_noise_row1, 1'b1); mdst = 5'd5; end
         6'd10: begin ma = w_ff[2]; mb = h0; mc = w_ff[3]; md = h1; mdst = 5'd10; end
         6'd11: begin ma = w_ff[4]; mb = h0; mc = w_ff[5]; md = h1; mdst = 5'd11; end
         6'd12: begin ma = h0; mb = w_ff[10]; mc = h1; md = w_ff[11];
            madd = {1'b0, cfg.meas_noise}; mdst = 5'd12; end
         6'd13: begin ma = h0; mb = w_ff[0]; mc = h1; md = w_ff[1]; mdst = 5'd15; end
         6'd14: begin ma = 32'sd0; mb = 32'sd0; mc = -32'sd1; md = w_ff[15];
            madd = z_ff; mdst = 5'd16; end
         6'd15: begin ma = w_ff[13]; mb = w_ff[16]; madd = w_ff[0]; mdst = 5'd17; end
         6'd16: begin ma = w_ff[14]; mb = w_ff[16]; madd = w_ff[1]; mdst = 5'd18; end
         6'd17: begin ma = -32'sd1; mb = w_ff[13]; mc = h0; md = 32'sd0;
            mdst = 5'd6; end
         6'd18: begin ma = -32'sd1; mb = w_ff[13]; mdst = 5'd7; end
         6'd19: begin ma = -32'sd1; mb = w_ff[14]; mdst = 5'd8; end
         6'd20: begin ma = -32'sd1; mb = w_ff[14]; mdst = 5'd9; end
         6'd21: begin ma = w_ff[6]; mb = w_ff[2]; mc = w_ff[7]; md = w_ff[4]; mdst = 5'd19; end
         6'd22: begin ma = w_ff[6]; mb = w_ff[3]; mc = w_ff[7]; md = w_ff[5]; mdst = 5'd20; end
         6'd23: begin ma = w_ff[8]; mb = w_ff[2]; mc = w_ff[9]; md = w_ff[4]; mdst = 5'd21; end
         6'd24: begin ma = w_ff[8]; mb = w_ff[3]; mc = w_ff[9]; md = w_ff[5]; mdst = 5'd22; end
         default: ;
      endcase
   end

   // The a-matrix ops form (I - k*h): the operands are re-selected below to k and h,
   // and the rounded product is subtracted from the identity term.
   logic signed [31:0] op_a, op_b;
   logic               raw_mode;
   always_comb begin
      raw_mode = 1'b0;
      op_a = (term_ff == 2'd0) ? ma : mc;
      op_b = (term_ff == 2'd0) ? mb : md;
      if (op_ff >= 6'd17 && op_ff <= 6'd20) begin
         op_a = w_ff[(op_ff <= 6'd18) ? 5'd13 : 5'd14];
         op_b = (op_ff == 6'd17 || op_ff == 6'd19) ? h0 : h1;
      end
      if (op_ff == 6'd14) raw_mode = 1'b1;
   end

   logic signed [63:0] prod;
   logic signed [65:0] prod_r;
   assign prod = op_a * op_b;
   assign prod_r = (66'(prod) + HALF_Q) >>> FRAC_BITS;

   logic signed [65:0] acc_next, fin;
   always_comb begin
      if (raw_mode) begin
         acc_next = 66'(z_ff) - 66'(w_ff[15]);
      end else if (op_ff >= 6'd17 && op_ff <= 6'd20) begin
         acc_next = ((op_ff == 6'd17 || op_ff == 6'd20) ? 66'(ONE_Q) : 66'sd0) - prod_r;
      end else begin
         acc_next = ((term_ff == 2'd0) ? 66'(madd) : acc_ff) + prod_r;
      end
      fin = acc_next;
   end

   logic signed [31:0] fin_sat;
   logic               fin_clamp;
   always_comb begin
      fin_clamp = 1'b0;
      fin_sat = fin[31:0];
      if (fin > WMAX) begin fin_sat = WMAX[31:0]; fin_clamp = 1'b1; end
      else if (fin < WMIN) begin fin_sat = WMIN[31:0]; fin_clamp = 1'b1; end
   end

   logic single;
   assign single = raw_mode || (op_ff >= 6'd15 && op_ff <= 6'd20);

   logic [DW-1:0] trial;
   logic [DW-1:0] num_abs;
   logic signed [31:0] ph_sel;
   logic [DW:0] kq;
   logic signed [DW+1:0] kval;
   logic signed [31:0] k_sat;
   logic k_clamp;
   assign trial = {rem_ff[DW-2:0], quo_ff[DW-1]};
   assign ph_sel = kidx_ff ? w_ff[11] : w_ff[10];
   assign num_abs = DW'(ph_sel[31] ? -66'(ph_sel) : 66'(ph_sel)) << FRAC_BITS;
   always_comb begin
      kq = {1'b0, quo_ff};
      kval = dneg_ff ? -$signed({1'b0, kq}) : $signed({1'b0, kq});
      k_clamp = 1'b0;
      k_sat = kval[31:0];
      if (kval > $signed((DW+2)'(WMAX))) begin k_sat = WMAX[31:0]; k_clamp = 1'b1; end
      else if (kval < $signed((DW+2)'(WMIN))) begin k_sat = WMIN[31:0]; k_clamp = 1'b1; end
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rvalid_ff;
   assign rsp.payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rvalid_ff <= 1'b0;
         w_ff[0] <= '0; w_ff[1] <= '0;
         w_ff[2] <= ONE_Q; w_ff[3] <= '0; w_ff[4] <= '0; w_ff[5] <= ONE_Q;
         op_ff <= '0; term_ff <= '0; acc_ff <= '0;
         clamp_ff <= 1'b0; skip_ff <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) rvalid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req.valid && req.ready) begin
                  cmd_ff <= req.payload.command;
                  z_ff <= req.payload.measurement;
                  clamp_ff <= 1'b0; skip_ff <= 1'b0;
                  term_ff <= '0; acc_ff <= '0;
                  if (req.payload.command == CMD_RESTART) begin
                     w_ff[0] <= wd(cfg.start_state, 1'b0);
                     w_ff[1] <= wd(cfg.start_state, 1'b1);
                     w_ff[2] <= ONE_Q; w_ff[3] <= '0; w_ff[4] <= '0; w_ff[5] <= ONE_Q;
                     state_ff <= S_OUT;
                  end else if (req.payload.command == CMD_UPDATE) begin
                     op_ff <= 6'd10; state_ff <= S_MAC;
                  end else begin
                     op_ff <= 6'd0; state_ff <= S_MAC;
                  end
               end
            end
            S_MAC: begin
               if (!single && term_ff == 2'd0) begin
                  acc_ff <= 66'(madd) + prod_r;
                  term_ff <= 2'd1;
               end else begin
                  w_ff[mdst] <= fin_sat;
                  if (fin_clamp) clamp_ff <= 1'b1;
                  term_ff <= '0; acc_ff <= '0;
                  if (op_ff == 6'd1) begin
                     op_ff <= 6'd2;
                  end else if (op_ff == 6'd9) begin
                     w_ff[0] <= w_ff[17]; w_ff[1] <= w_ff[18];
                     if (cmd_ff == CMD_BOTH) begin
                        op_ff <= 6'd10;
                     end else begin
                        state_ff <= S_OUT;
                     end
                  end else if (op_ff == 6'd12) begin
                     if (fin_sat <= 0) begin
                        skip_ff <= 1'b1; state_ff <= S_OUT;
                     end else begin
                        kidx_ff <= 1'b0; state_ff <= S_DIV; dcnt_ff <= '0;
                     end
                  end else if (op_ff == 6'd24) begin
                     w_ff[0] <= w_ff[17]; w_ff[1] <= w_ff[18];
                     w_ff[2] <= w_ff[19]; w_ff[3] <= w_ff[20];
                     w_ff[4] <= w_ff[21]; w_ff[5] <= fin_sat;
                     state_ff <= S_OUT;
                  end else begin
                     op_ff <= op_ff + 6'd1;
                  end
               end
            end
            S_DIV: begin
               if (dcnt_ff == 7'd0) begin
                  quo_ff <= num_abs; rem_ff <= '0;
                  dvs_ff <= DW'(w_ff[12]);
                  dneg_ff <= ph_sel[31];
                  dcnt_ff <= 7'd1;
               end else if (dcnt_ff <= 7'(DW)) begin
                  if (trial >= dvs_ff) begin
                     rem_ff <= trial - dvs_ff;
                     quo_ff <= {quo_ff[DW-2:0], 1'b1};
                  end else begin
                     rem_ff <= trial;
                     quo_ff <= {quo_ff[DW-2:0], 1'b0};
                  end
                  dcnt_ff <= dcnt_ff + 7'd1;
               end else begin
                  w_ff[kidx_ff ? 5'd14 : 5'd13] <= k_sat;
                  if (k_clamp) clamp_ff <= 1'b1;
                  dcnt_ff <= '0;
                  if (kidx_ff) begin
                     op_ff <= 6'd13; state_ff <= S_MAC;
                  end else begin
                     kidx_ff <= 1'b1;
                  end
               end
            end
            S_OUT: begin
               if (!rvalid_ff) begin
                  rsp_ff.position_estimate <= w_ff[0];
                  rsp_ff.velocity_estimate <= w_ff[1];
                  rsp_ff.status <= skip_ff ? STATUS_SKIP : (clamp_ff ? STATUS_SAT : STATUS_OK);
                  rvalid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req.ready) else $error("ready while busy");
   a_out_after: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && !rvalid_ff) |=> rvalid_ff) else $error("no response");
   a_skip_status: assert property (@(posedge clock) disable iff (reset)
      $rose(rvalid_ff) && skip_ff |-> rsp_ff.status == STATUS_SKIP) else $error("status");
endmodule

// ===== hw/rtl/kf2_csr.sv =====
// ----------------------------------------------------------------------------
// Kalman filter register file
// APB-style register bank holding the filter model matrices, noise and start state.
// ----------------------------------------------------------------------------
module kf2_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [kf2_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [63:0]                   csr_pwdata,
   output logic [63:0]                   csr_prdata,
   output logic                          csr_pready,
   output kf2_pkg::cfg_type              cfg
);
   import kf2_pkg::*;

   cfg_type    cfg_ff;
   logic [2:0] idx;
   logic       wr;

   assign idx = csr_paddr[5:3];
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trans_row0 <= 64'd65536;
         cfg_ff.trans_row1 <= 64'd65536 << 32;
         cfg_ff.meas_row <= 64'd0;
         cfg_ff.proc_noise_row0 <= 64'd65536;
         cfg_ff.proc_noise_row1 <= 64'd65536 << 32;
         cfg_ff.meas_noise <= 31'd65536;
         cfg_ff.start_state <= 64'd0;
      end else if (wr) begin
         case (idx)
            REG_TRANS0: cfg_ff.trans_row0 <= csr_pwdata;
            REG_TRANS1: cfg_ff.trans_row1 <= csr_pwdata;
            REG_MEAS:   cfg_ff.meas_row <= csr_pwdata;
            REG_QN0:    cfg_ff.proc_noise_row0 <= csr_pwdata;
            REG_QN1:    cfg_ff.proc_noise_row1 <= csr_pwdata;
            REG_RN:     cfg_ff.meas_noise <= csr_pwdata[30:0];
            REG_START:  cfg_ff.start_state <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_TRANS0: csr_prdata = cfg_ff.trans_row0;
         REG_TRANS1: csr_prdata = cfg_ff.trans_row1;
         REG_MEAS:   csr_prdata = cfg_ff.meas_row;
         REG_QN0:    csr_prdata = cfg_ff.proc_noise_row0;
         REG_QN1:    csr_prdata = cfg_ff.proc_noise_row1;
         REG_RN:     csr_prdata = {33'd0, cfg_ff.meas_noise};
         REG_START:  csr_prdata = cfg_ff.start_state;
         default:    csr_prdata = 64'd0;
      endcase
   end
endmodule

// ===== dv/tb_kalman_filter_2state_scalar_meas_top.sv =====
// ----------------------------------------------------------------------------
// Kalman filter block testbench
// Drives predict, update, combined and restart beats into the filter under
// several register settings. The expected estimate and status of every beat
// are computed in fixed point here and compared with each response beat.
// ----------------------------------------------------------------------------
module tb_kalman_filter_2state_scalar_meas_top;
   timeunit 1ns;
   timeprecision 1ps;
   import kf2_pkg::*;

   localparam int  FRAC = DEFAULT_FRAC_BITS;
   localparam longint ONE = longint'(1) << FRAC;
   localparam longint HALF = longint'(1) << (FRAC - 1);
   localparam longint WMAX = 64'sd2147483647;
   localparam longint WMIN = -64'sd2147483648;
   localparam int  SETTLE = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic csr_pready;

   kf2_req_if req_if();
   kf2_rsp_if rsp_if();

   kalman_filter_2state_scalar_meas_top u_dut (
      .clock(clock), .reset(reset), .req(req_if.sink), .rsp(rsp_if.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   req_type pending_beats[$];
   rsp_type expected_estimates[$];
   int     error_count = 0;
   bit     calm = 1'b0;
   int     rsp_hold = 0;

   logic [63:0] reg_shadow[7];
   longint est[2];
   longint cov[4];
   bit     clamp_hit;

   function automatic longint word_lo(logic [63:0] r);
      return longint'($signed(r[31:0]));
   endfunction

   function automatic longint word_hi(logic [63:0] r);
      return longint'($signed(r[63:32]));
   endfunction

   function automatic longint clamp32(longint v);
      if (v > WMAX) begin
         clamp_hit = 1'b1;
         return WMAX;
      end
      if (v < WMIN) begin
         clamp_hit = 1'b1;
         return WMIN;
      end
      return v;
   endfunction

   function automatic longint fmul(longint a, longint b);
      return (a * b + HALF) >>> FRAC;
   endfunction

   function automatic void run_predict();
      longint f[4], q[4], fp[4], nx[2];
      f[0] = word_lo(reg_shadow[REG_TRANS0]); f[1] = word_hi(reg_shadow[REG_TRANS0]);
      f[2] = word_lo(reg_shadow[REG_TRANS1]); f[3] = word_hi(reg_shadow[REG_TRANS1]);
      q[0] = word_lo(reg_shadow[REG_QN0]);    q[1] = word_hi(reg_shadow[REG_QN0]);
      q[2] = word_lo(reg_shadow[REG_QN1]);    q[3] = word_hi(reg_shadow[REG_QN1]);
      for (int i = 0; i < 2; i++)
         nx[i] = clamp32(fmul(f[2*i], est[0]) + fmul(f[2*i+1], est[1]));
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++)
            fp[2*i+j] = clamp32(fmul(f[2*i], cov[j]) + fmul(f[2*i+1], cov[2+j]));
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++)
            cov[2*i+j] = clamp32(fmul(fp[2*i], f[2*j]) + fmul(fp[2*i+1], f[2*j+1])
                                 + q[2*i+j]);
      est[0] = nx[0];
      est[1] = nx[1];
   endfunction

   function automatic bit run_update(longint z);
      longint h[2], ph[2], k[2], a[4], np[4], s, hx, innov;
      h[0] = word_lo(reg_shadow[REG_MEAS]);
      h[1] = word_hi(reg_shadow[REG_MEAS]);
      for (int i = 0; i < 2; i++)
         ph[i] = clamp32(fmul(cov[2*i], h[0]) + fmul(cov[2*i+1], h[1]));
      s = clamp32(fmul(h[0], ph[0]) + fmul(h[1], ph[1])
                  + longint'(reg_shadow[REG_RN][30:0]));
      if (s <= 0) return 1'b0;
      for (int i = 0; i < 2; i++)
         k[i] = clamp32((ph[i] * ONE) / s);
      hx = clamp32(fmul(h[0], est[0]) + fmul(h[1], est[1]));
      innov = clamp32(z - hx);
      for (int i = 0; i < 2; i++)
         est[i] = clamp32(est[i] + fmul(k[i], innov));
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++)
            a[2*i+j] = clamp32((i == j ? ONE : 0) - fmul(k[i], h[j]));
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++)
            np[2*i+j] = clamp32(fmul(a[2*i], cov[j]) + fmul(a[2*i+1], cov[2+j]));
      for (int i = 0; i < 4; i++) cov[i] = np[i];
      return 1'b1;
   endfunction

   function automatic rsp_type filter_step(req_type beat);
      rsp_type r;
      bit skipped;
      skipped = 1'b0;
      clamp_hit = 1'b0;
      if (beat.command == CMD_RESTART) begin
         est[0] = word_lo(reg_shadow[REG_START]);
         est[1] = word_hi(reg_shadow[REG_START]);
         cov[0] = ONE; cov[1] = 0; cov[2] = 0; cov[3] = ONE;
      end else begin
         if (beat.command == CMD_PREDICT || beat.command == CMD_BOTH) run_predict();
         if (beat.command == CMD_UPDATE || beat.command == CMD_BOTH)
            skipped = !run_update(longint'(beat.measurement));
      end
      r.position_estimate = est[0][31:0];
      r.velocity_estimate = est[1][31:0];
      r.status = skipped ? STATUS_SKIP : (clamp_hit ? STATUS_SAT : STATUS_OK);
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Request driver: holds valid until the beat is taken.
   always @(posedge clock) begin
      logic busy;
      logic nv;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         busy = req_if.valid;
         if (req_if.valid && req_if.ready) begin
            expected_estimates.push_back(filter_step(pending_beats[0]));
            pending_beats.pop_front();
            busy = 1'b0;
         end
         nv = busy;
         if (!busy && pending_beats.size() > 0 && (calm || $urandom_range(99) >= 13)) begin
            nv = 1'b1;
            req_if.payload <= pending_beats[0];
         end
         req_if.valid <= nv;
      end
   end

   // Response monitor and ready generator.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_estimates.size() == 0) begin
               report_mismatch("unexpected beat", 0, 0);
            end else begin
               want = expected_estimates.pop_front();
               if (rsp_if.payload.position_estimate !== want.position_estimate)
                  report_mismatch("position", rsp_if.payload.position_estimate,
                                  want.position_estimate);
               if (rsp_if.payload.velocity_estimate !== want.velocity_estimate)
                  report_mismatch("velocity", rsp_if.payload.velocity_estimate,
                                  want.velocity_estimate);
               if (rsp_if.payload.status !== want.status)
                  report_mismatch("status", rsp_if.payload.status, want.status);
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold <= rsp_hold - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= calm || $urandom_range(99) >= 13;
         end
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [63:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(idx) << 3;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      reg_shadow[idx] = (idx == REG_RN) ? {33'd0, value[30:0]} : value;
   endtask

   task automatic drain();
      wait (pending_beats.size() == 0 && expected_estimates.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic queue_beat(logic [1:0] cmd, logic [31:0] z);
      req_type b;
      b.command = cmd;
      b.measurement = z;
      pending_beats.push_back(b);
   endtask

   function automatic logic [31:0] modest_word();
      return 32'($urandom_range(0, 262143)) - 32'd131072;
   endfunction

   function automatic logic [31:0] any_measurement();
      if ($urandom_range(9) == 0) return $urandom;
      return modest_word() <<< $urandom_range(0, 4);
   endfunction

   task automatic random_settings(bit extreme);
      logic [63:0] v;
      for (int r = 0; r < 7; r++) begin
         if (extreme) v = {$urandom, $urandom};
         else v = {modest_word(), modest_word()};
         if (r == REG_RN && !extreme) v = 64'($urandom_range(0, 131072));
         write_reg(3'(r), v);
      end
   endtask

   initial begin
      logic [1:0] cmd;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      reg_shadow[REG_TRANS0] = 64'd65536;
      reg_shadow[REG_TRANS1] = 64'd65536 << 32;
      reg_shadow[REG_MEAS]   = 64'd0;
      reg_shadow[REG_QN0]    = 64'd65536;
      reg_shadow[REG_QN1]    = 64'd65536 << 32;
      reg_shadow[REG_RN]     = 64'd65536;
      reg_shadow[REG_START]  = 64'd0;
      est[0] = 0; est[1] = 0;
      cov[0] = ONE; cov[1] = 0; cov[2] = 0; cov[3] = ONE;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: defaults, then every command and corner.
      queue_beat(CMD_PREDICT, 32'h7FFF_FFFF);
      queue_beat(CMD_UPDATE, 32'h8000_0000);
      queue_beat(CMD_BOTH, 32'h0001_0000);
      queue_beat(CMD_RESTART, 32'hFFFF_FFFF);
      drain();
      write_reg(REG_MEAS, {32'd0, 32'h0001_0000});
      write_reg(REG_TRANS0, {32'h0000_8000, 32'h0001_0000});
      write_reg(REG_START, {32'h8000_0000, 32'h7FFF_FFFF});
      queue_beat(CMD_RESTART, 32'd0);
      queue_beat(CMD_UPDATE, 32'h7FFF_FFFF);
      queue_beat(CMD_UPDATE, 32'h8000_0000);
      queue_beat(CMD_BOTH, 32'h0000_0000);
      queue_beat(CMD_PREDICT, 32'd0);
      drain();
      write_reg(REG_MEAS, 64'd0);
      write_reg(REG_RN, 64'hFFFF_FFFF_0000_0000);
      queue_beat(CMD_UPDATE, 32'h0001_0000);
      queue_beat(CMD_BOTH, 32'h0001_0000);
      drain();
      write_reg(REG_TRANS1, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
      write_reg(REG_QN0, {32'h8000_0000, 32'h8000_0000});
      write_reg(REG_QN1, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
      queue_beat(CMD_PREDICT, 32'd0);
      queue_beat(CMD_BOTH, 32'd5);
      drain();
      write_reg(REG_RN, 64'h7FFF_FFFF);
      drain();
      queue_beat(CMD_BOTH, 32'h0000_1234);
      queue_beat(CMD_RESTART, 32'd0);
      queue_beat(CMD_UPDATE, 32'h0000_1234);
      drain();

      // Random phases; each opens with a restart.
      for (int phase = 0; phase < 12; phase++) begin
         random_settings(phase % 4 == 3);
         calm = (phase == 5);
         queue_beat(CMD_RESTART, $urandom);
         for (int n = 0; n < 39; n++) begin
            cmd = $urandom_range(0, 9) == 0 ? CMD_RESTART : 2'($urandom_range(0, 2));
            queue_beat(cmd, any_measurement());
         end
         if (phase == 7) begin
            wait (pending_beats.size() < 37);
            rsp_hold = 600;
         end
         drain();
      end
      calm = 1'b0;
      drain();
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
